// ===== hw/rtl/cpf_pkg.sv =====
// shared types, codes and constants for the command packet framer
package cpf_pkg;

  localparam int MAX_FRAME_DEF = 20;
  localparam int LEN_W         = 5;
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;
  localparam logic [1:0] ST_MISMATCH  = 2'd3;

  localparam logic [7:0] CHR_START = 8'h21;
  localparam logic [7:0] CHR_ACCEL = 8'h41;
  localparam logic [7:0] CHR_GYRO  = 8'h47;
  localparam logic [7:0] CHR_MAG   = 8'h4D;
  localparam logic [7:0] CHR_QUAT  = 8'h51;
  localparam logic [7:0] CHR_BTN   = 8'h42;
  localparam logic [7:0] CHR_COLOR = 8'h43;
  localparam logic [7:0] CHR_LOC   = 8'h4C;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BTN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOC     = 3'd7;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [LEN_W-1:0]  LEN_ACCEL_RST = 5'd15;
  localparam logic [LEN_W-1:0]  LEN_GYRO_RST  = 5'd15;
  localparam logic [LEN_W-1:0]  LEN_MAG_RST   = 5'd15;
  localparam logic [LEN_W-1:0]  LEN_QUAT_RST  = 5'd19;
  localparam logic [LEN_W-1:0]  LEN_BTN_RST   = 5'd5;
  localparam logic [LEN_W-1:0]  LEN_COLOR_RST = 5'd6;
  localparam logic [LEN_W-1:0]  LEN_LOC_RST   = 5'd15;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       frame_byte;
    logic [LEN_W-1:0] byte_index;
    logic [LEN_W-1:0] frame_length;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic emit_start;
    logic load_status;
    logic load_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close_req;
    logic good;
    logic out_free;
    logic last_idx;
  } dp_status_t;

endpackage

// ===== hw/rtl/command_packet_framer.sv =====
// top level of the command packet framer: checksummed frame assembly and emission
// sequence: a word is taken, judged the next cycle; a closing word has its status
//   item loaded in S_EVAL, or its first byte in S_LOAD after S_READ, each once the
//   result register is free; one word is taken at a time, in S_IDLE only; a good
//   frame streams its bytes through S_READ and S_LOAD in turn (registered read)
// reset: synchronous active-low rst_n restores settings and empties the frame
module command_packet_framer
  import cpf_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  dp_cmd;
  dp_status_t dp_stat;

  cpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  cpf_dpath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/cpf_ctrl.sv =====
// controller state machine of the command packet framer
module cpf_ctrl
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_stat,
  output ctrl_cmd_t  dp_cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.take = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (!dp_stat.close_req) begin
          state_nxt = S_IDLE;
        end else if (dp_stat.good) begin
          dp_cmd.emit_start = 1'b1;
          state_nxt         = S_READ;
        end else if (dp_stat.out_free) begin
          dp_cmd.load_status = 1'b1;
          dp_cmd.clear       = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (dp_stat.out_free) begin
          dp_cmd.load_byte = 1'b1;
          if (dp_stat.last_idx) begin
            dp_cmd.clear = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/cpf_dpath.sv =====
// frame store, counters, checksum, settings and result register of the framer
module cpf_dpath
  import cpf_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctrl_cmd_t             dp_cmd,
  output dp_status_t            dp_stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W = $clog2(MAX_FRAME);
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

  // settings
  logic [TICK_W-1:0] timeout_r;
  logic [LEN_W-1:0]  len_accel_r, len_gyro_r, len_mag_r, len_quat_r;
  logic [LEN_W-1:0]  len_btn_r, len_color_r, len_loc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      len_accel_r <= LEN_ACCEL_RST;
      len_gyro_r  <= LEN_GYRO_RST;
      len_mag_r   <= LEN_MAG_RST;
      len_quat_r  <= LEN_QUAT_RST;
      len_btn_r   <= LEN_BTN_RST;
      len_color_r <= LEN_COLOR_RST;
      len_loc_r   <= LEN_LOC_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_r   <= cfg_wdata[TICK_W-1:0];
        REG_ACCEL:   len_accel_r <= cfg_wdata[LEN_W-1:0];
        REG_GYRO:    len_gyro_r  <= cfg_wdata[LEN_W-1:0];
        REG_MAG:     len_mag_r   <= cfg_wdata[LEN_W-1:0];
        REG_QUAT:    len_quat_r  <= cfg_wdata[LEN_W-1:0];
        REG_BTN:     len_btn_r   <= cfg_wdata[LEN_W-1:0];
        REG_COLOR:   len_color_r <= cfg_wdata[LEN_W-1:0];
        REG_LOC:     len_loc_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;
  logic              tmo_r, tmo_nxt;
  logic              was_byte_r, was_byte_nxt;
  logic [7:0]        byte0_r, byte1_r, lastb_r;
  logic [ADDR_W-1:0] idx_r;
  logic [7:0]        rdata_r;
  logic [7:0]        mem [MAX_FRAME];

  logic              is_start;
  logic [CNT_W-1:0]  wr_base;
  logic [7:0]        sum_base;
  logic              mem_we;

  assign is_start = (in_data.rx_byte == CHR_START);
  assign wr_base  = is_start ? '0 : count_r;
  assign sum_base = is_start ? 8'd0 : sum_r;
  assign mem_we   = dp_cmd.take && (in_data.cmd == CMD_BYTE) && (wr_base < CNT_MAX);

  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    idle_nxt     = idle_r;
    tmo_nxt      = tmo_r;
    was_byte_nxt = was_byte_r;
    if (dp_cmd.clear) begin
      count_nxt    = '0;
      sum_nxt      = 8'd0;
      idle_nxt     = timeout_r;
      tmo_nxt      = 1'b0;
      was_byte_nxt = 1'b0;
    end else if (dp_cmd.take) begin
      was_byte_nxt = (in_data.cmd == CMD_BYTE);
      if (in_data.cmd == CMD_TICK) begin
        if (idle_r <= TICK_W'(1)) begin
          tmo_nxt = 1'b1;
        end else begin
          idle_nxt = idle_r - TICK_W'(1);
        end
      end else begin
        count_nxt = wr_base;
        sum_nxt   = sum_base;
        if (wr_base < CNT_MAX) begin
          count_nxt = wr_base + CNT_W'(1);
          sum_nxt   = sum_base + in_data.rx_byte;
        end
        idle_nxt = timeout_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= 8'd0;
      idle_r     <= TIMEOUT_RST;
      tmo_r      <= 1'b0;
      was_byte_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      idle_r     <= idle_nxt;
      tmo_r      <= tmo_nxt;
      was_byte_r <= was_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lastb_r <= in_data.rx_byte;
      if (wr_base == CNT_W'(0)) begin
        byte0_r <= in_data.rx_byte;
      end
      if (wr_base == CNT_W'(1)) begin
        byte1_r <= in_data.rx_byte;
      end
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_base[ADDR_W-1:0]] <= in_data.rx_byte;
    end
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit_start) begin
      idx_r <= '0;
    end else if (dp_cmd.load_byte) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // close decision and verdict
  logic [LEN_W-1:0] want;
  logic             len_hit;
  logic [7:0]       pre_sum;
  logic             sum_ok;
  logic [1:0]       verdict;

  always_comb begin
    unique case (byte1_r)
      CHR_ACCEL: want = len_accel_r;
      CHR_GYRO:  want = len_gyro_r;
      CHR_MAG:   want = len_mag_r;
      CHR_QUAT:  want = len_quat_r;
      CHR_BTN:   want = len_btn_r;
      CHR_COLOR: want = len_color_r;
      CHR_LOC:   want = len_loc_r;
      default:   want = '0;
    endcase
  end

  assign len_hit = (count_r >= CNT_W'(2)) && (want >= LEN_W'(2))
                   && (CMP_W'(count_r) == CMP_W'(want));
  assign pre_sum = sum_r - lastb_r;
  assign sum_ok  = (~pre_sum == lastb_r);

  always_comb begin
    priority if (count_r == '0) begin
      verdict = ST_EMPTY;
    end else if (byte0_r != CHR_START) begin
      verdict = ST_BAD_START;
    end else if (!sum_ok) begin
      verdict = ST_MISMATCH;
    end else begin
      verdict = ST_GOOD;
    end
  end

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.load_status || dp_cmd.load_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_status) begin
      out_item_r.status       <= verdict;
      out_item_r.frame_byte   <= 8'd0;
      out_item_r.byte_index   <= '0;
      out_item_r.frame_length <= LEN_W'(count_r);
      out_item_r.last         <= 1'b1;
    end else if (dp_cmd.load_byte) begin
      out_item_r.status       <= ST_GOOD;
      out_item_r.frame_byte   <= rdata_r;
      out_item_r.byte_index   <= LEN_W'(idx_r);
      out_item_r.frame_length <= LEN_W'(count_r);
      out_item_r.last         <= dp_stat.last_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // length checks only follow a byte, ticks close on the idle count alone
  assign dp_stat.close_req = tmo_r || (was_byte_r && ((count_r >= CNT_MAX) || len_hit));
  assign dp_stat.good      = (verdict == ST_GOOD);
  assign dp_stat.out_free  = !out_valid_r || out_ready;
  assign dp_stat.last_idx  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

endmodule

// ===== verif/tb_command_packet_framer.sv =====
// testbench for command_packet_framer: directed frames, then random frames checked against a predictor
module tb_command_packet_framer
  import cpf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic      cmd;
    logic [7:0] rx;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [7:0]  fr_store [MAX_FRAME_DEF];
  int          fr_count;
  logic [15:0] idle_left;
  logic [7:0]  fr_sum;
  logic [15:0] reg_val  [8];
  logic [15:0] reg_next [8];

  out_item_t step_items [$];
  out_item_t results_due [$];
  logic [7:0] type_chr [7];

  int mismatch_count = 0;
  int results_seen = 0;
  int words_sent = 0;
  int calm_words = 0;

  dir_row_t dir_rows [25] = '{
    '{CMD_BYTE, CHR_START, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b1, '{ST_MISMATCH, 8'h00, 5'd0, 5'd1, 1'b1}},
    '{CMD_TICK, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 5'd0, 5'd0, 1'b1}},
    '{CMD_BYTE, 8'h00, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b1, '{ST_BAD_START, 8'h00, 5'd0, 5'd1, 1'b1}},
    '{CMD_BYTE, CHR_START, 1'b0, '0},
    '{CMD_BYTE, CHR_BTN, 1'b0, '0},
    '{CMD_BYTE, 8'hFF, 1'b0, '0},
    '{CMD_BYTE, 8'h00, 1'b0, '0},
    '{CMD_BYTE, 8'h9D, 1'b0, '0},
    '{CMD_BYTE, CHR_START, 1'b0, '0},
    '{CMD_BYTE, CHR_COLOR, 1'b0, '0},
    '{CMD_BYTE, 8'h01, 1'b0, '0},
    '{CMD_BYTE, 8'h02, 1'b0, '0},
    '{CMD_BYTE, 8'h03, 1'b0, '0},
    '{CMD_BYTE, 8'h96, 1'b1, '{ST_MISMATCH, 8'h00, 5'd0, 5'd6, 1'b1}},
    '{CMD_BYTE, CHR_START, 1'b0, '0},
    '{CMD_BYTE, CHR_ACCEL, 1'b0, '0},
    '{CMD_BYTE, 8'h55, 1'b0, '0},
    '{CMD_BYTE, CHR_START, 1'b0, '0},
    '{CMD_BYTE, CHR_BTN, 1'b0, '0},
    '{CMD_BYTE, 8'h10, 1'b0, '0},
    '{CMD_BYTE, 8'h20, 1'b0, '0},
    '{CMD_BYTE, 8'h6C, 1'b0, '0},
    '{CMD_TICK, 8'hFF, 1'b1, '{ST_EMPTY, 8'h00, 5'd0, 5'd0, 1'b1}}
  };

  command_packet_framer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic int len_for_type(input logic [7:0] t);
    case (t)
      CHR_ACCEL: return reg_val[REG_ACCEL];
      CHR_GYRO:  return reg_val[REG_GYRO];
      CHR_MAG:   return reg_val[REG_MAG];
      CHR_QUAT:  return reg_val[REG_QUAT];
      CHR_BTN:   return reg_val[REG_BTN];
      CHR_COLOR: return reg_val[REG_COLOR];
      CHR_LOC:   return reg_val[REG_LOC];
      default:   return 0;
    endcase
  endfunction

  task automatic frame_close();
    logic [7:0] chk;
    logic [7:0] head;
    if (fr_count == 0) begin
      step_items.push_back(out_item_t'{ST_EMPTY, 8'h00, 5'd0, 5'd0, 1'b1});
    end else if (fr_store[0] != CHR_START) begin
      step_items.push_back(out_item_t'{ST_BAD_START, 8'h00, 5'd0, LEN_W'(fr_count), 1'b1});
    end else begin
      chk = fr_store[fr_count-1];
      head = fr_sum - chk;
      if ((~head) != chk) begin
        step_items.push_back(out_item_t'{ST_MISMATCH, 8'h00, 5'd0, LEN_W'(fr_count), 1'b1});
      end else begin
        for (int i = 0; i < fr_count; i++) begin
          step_items.push_back(out_item_t'{ST_GOOD, fr_store[i], LEN_W'(i), LEN_W'(fr_count),
                                           (i + 1 == fr_count)});
        end
      end
    end
    fr_count = 0;
    fr_sum = 8'h00;
    idle_left = reg_val[REG_TIMEOUT];
  endtask

  task automatic framer_predict(input in_item_t w);
    int want;
    step_items.delete();
    if (w.cmd == CMD_TICK) begin
      if (idle_left <= 16'd1) frame_close();
      else idle_left = idle_left - 16'd1;
    end else begin
      if (w.rx_byte == CHR_START) begin
        fr_count = 0;
        fr_sum = 8'h00;
      end
      if (fr_count < MAX_FRAME_DEF) begin
        fr_store[fr_count] = w.rx_byte;
        fr_count++;
        fr_sum = fr_sum + w.rx_byte;
      end
      idle_left = reg_val[REG_TIMEOUT];
      if (fr_count >= MAX_FRAME_DEF) begin
        frame_close();
      end else if (fr_count >= 2) begin
        want = len_for_type(fr_store[1]);
        if (want >= 2 && fr_count == want) frame_close();
      end
    end
  endtask

  task automatic put_word(input in_item_t w);
    int gap;
    int r;
    gap = 0;
    if (calm_words > 0) begin
      calm_words--;
    end else begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(8, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
      if ($urandom_range(0, 19) == 0) calm_words = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_word(input in_item_t w);
    put_word(w);
    framer_predict(w);
    foreach (step_items[i]) results_due.push_back(step_items[i]);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(in_item_t'{CMD_TICK, 8'($urandom)});
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(in_item_t'{CMD_BYTE, b});
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings();
    for (int k = REG_TIMEOUT; k <= REG_LOC; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_wdata <= reg_next[k];
      @(posedge clk);
      reg_val[k] = (k == REG_TIMEOUT) ? reg_next[k] : {11'b0, reg_next[k][LEN_W-1:0]};
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic choose_settings(input int phase);
    logic [LEN_W-1:0] len;
    case (phase)
      0:       reg_next[REG_TIMEOUT] = 16'd1;
      1:       reg_next[REG_TIMEOUT] = 16'hFFFF;
      2:       reg_next[REG_TIMEOUT] = 16'd0;
      default: reg_next[REG_TIMEOUT] = 16'($urandom_range(2, 8));
    endcase
    for (int k = REG_ACCEL; k <= REG_LOC; k++) begin
      case (phase)
        1:       len = $urandom_range(0, 1) ? 5'd2 : 5'd20;
        2:       len = 5'($urandom_range(0, 31));
        4:       len = 5'($urandom_range(2, 12));
        default: len = 5'($urandom_range(2, 20));
      endcase
      reg_next[k] = {11'($urandom), len};
    end
  endtask

  // enough ticks to close the open frame when the timeout is short
  task automatic tick_burst();
    int n;
    n = reg_val[REG_TIMEOUT];
    if (n == 0) n = 1;
    if (n > 12) n = $urandom_range(1, 12);
    repeat (n) send_tick();
  endtask

  task automatic send_frame();
    logic [7:0] kind_chr;
    logic [7:0] b;
    logic [7:0] sum;
    int n;
    int r;
    bit corrupt;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      kind_chr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : type_chr[$urandom_range(0, 6)];
      n = len_for_type(kind_chr);
      if (n < 2 || n > MAX_FRAME_DEF) n = MAX_FRAME_DEF;
      corrupt = ($urandom_range(0, 99) < 15);
      sum = 8'h00;
      for (int k = 0; k < n; k++) begin
        if (k == 0) begin
          b = CHR_START;
        end else if (k == 1) begin
          b = kind_chr;
        end else if (k == n - 1) begin
          b = ~sum;
          if (corrupt) b = b ^ 8'($urandom_range(1, 255));
        end else begin
          b = 8'($urandom);
          if (b == CHR_START) b = 8'h20;
        end
        sum = sum + b;
        if (k > 0 && reg_val[REG_TIMEOUT] >= 16'd2 && $urandom_range(0, 9) == 0) send_tick();
        send_byte(b);
      end
    end else if (r < 75) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        if (b == CHR_START) b = 8'h00;
        send_byte(b);
      end
      tick_burst();
    end else if (r < 85) begin
      send_byte(CHR_START);
      send_byte(type_chr[$urandom_range(0, 6)]);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      tick_burst();
    end else if ($urandom_range(0, 1) == 0) begin
      tick_burst();
    end else begin
      repeat ($urandom_range(1, 4)) send_word(in_item_t'(9'($urandom)));
    end
  endtask

  always @(negedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        note_mismatch($sformatf("word with nothing awaited: %h", out_data));
      end else begin
        want = results_due.pop_front();
        if (out_data.status != want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.frame_byte != want.frame_byte)
          note_mismatch($sformatf("frame_byte %h, want %h", out_data.frame_byte,
                                  want.frame_byte));
        if (out_data.byte_index != want.byte_index)
          note_mismatch($sformatf("byte_index %0d, want %0d", out_data.byte_index,
                                  want.byte_index));
        if (out_data.frame_length != want.frame_length)
          note_mismatch($sformatf("frame_length %0d, want %0d", out_data.frame_length,
                                  want.frame_length));
        if (out_data.last != want.last)
          note_mismatch($sformatf("last %0d, want %0d", out_data.last, want.last));
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int stall_left;
    int calm;
    bit held;
    stall_left = 0;
    calm = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (!held && results_seen >= 40) begin
        // long hold-off so the frame store backs up into the input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 99) < 2) begin
          calm = $urandom_range(50, 150);
        end else if ($urandom_range(0, 99) < 30) begin
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : stimulus
    int mark;
    type_chr = '{CHR_ACCEL, CHR_GYRO, CHR_MAG, CHR_QUAT, CHR_BTN, CHR_COLOR, CHR_LOC};
    foreach (fr_store[i]) fr_store[i] = 8'h00;
    fr_count = 0;
    fr_sum = 8'h00;
    reg_val[REG_TIMEOUT] = TIMEOUT_RST;
    reg_val[REG_ACCEL] = LEN_ACCEL_RST;
    reg_val[REG_GYRO] = LEN_GYRO_RST;
    reg_val[REG_MAG] = LEN_MAG_RST;
    reg_val[REG_QUAT] = LEN_QUAT_RST;
    reg_val[REG_BTN] = LEN_BTN_RST;
    reg_val[REG_COLOR] = LEN_COLOR_RST;
    reg_val[REG_LOC] = LEN_LOC_RST;
    idle_left = TIMEOUT_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: shortest timeout, reset frame lengths
    reg_next = reg_val;
    reg_next[REG_TIMEOUT] = 16'd1;
    apply_settings();
    foreach (dir_rows[i]) begin
      put_word(in_item_t'{dir_rows[i].cmd, dir_rows[i].rx});
      framer_predict(in_item_t'{dir_rows[i].cmd, dir_rows[i].rx});
      if (dir_rows[i].typed) results_due.push_back(dir_rows[i].want);
      else foreach (step_items[j]) results_due.push_back(step_items[j]);
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain_and_settle();
      choose_settings(phase);
      apply_settings();
      mark = words_sent;
      while (words_sent - mark < 20) send_frame();
    end

    drain_and_settle();
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_ctrl.sv
hw/rtl/cpf_dpath.sv
hw/rtl/command_packet_framer.sv
verif/tb_command_packet_framer.sv
